[rtl/prs_pkg.sv]
package prs_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 20;
    localparam int ADDR_W      = 12;
    localparam int LANES       = 4;
    localparam int PROD_LANE_W = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_LANE_W + 7;
    localparam int ADV_DEPTH   = 64;
    localparam int MAX_RESULTS = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 36;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_COEF   = 2'd1;
    localparam logic [1:0] ACT_ADV    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN = 2'd3;

    localparam logic [CFG_DATA_W-1:0] MIN_STEP = 36'd67108864;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic signed [SAMPLE_W-1:0] sample_c;
        logic signed [SAMPLE_W-1:0] sample_d;
        logic [ADDR_W-1:0]          table_address;
        logic signed [COEF_W-1:0]   table_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result_a;
        logic signed [SAMPLE_W-1:0] result_b;
        logic signed [SAMPLE_W-1:0] result_c;
        logic signed [SAMPLE_W-1:0] result_d;
        logic                       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic coef_we;
        logic adv_we;
        logic setup;
        logic issue;
        logic first;
        logic last_tap;
        logic load_out;
        logic last_of_run;
    } t_dp_cmd;

    typedef struct packed {
        logic       acc_done;
        logic       out_busy;
        logic [7:0] adv_data;
    } t_dp_sts;

endpackage

[rtl/prs_if.sv]
interface prs_in_if;
    logic               valid;
    logic               ready;
    prs_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prs_out_if;
    logic               valid;
    logic               ready;
    prs_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/prs_ctrl.sv]
module prs_ctrl #(
    parameter int MAX_TAPS  = 32,
    parameter int FRAC_BITS = 26
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_action,
    output prs_pkg::t_dp_cmd                   o_cmd,
    input  prs_pkg::t_dp_sts                   i_sts,
    output logic [((33 - FRAC_BITS > 7) ? 33 - FRAC_BITS : 7)-1:0] o_row,
    output logic [FRAC_BITS-1:0]               o_frac,
    output logic [5:0]                         o_taps,
    output logic [2:0]                         o_lanes,
    output logic [5:0]                         o_phase
);
    import prs_pkg::*;

    localparam int ROW_W = (33 - FRAC_BITS > 7) ? 33 - FRAC_BITS : 7;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [39:0] r_pos, n_pos;
    logic [5:0]  r_phase, n_phase;
    logic [6:0]  r_n, n_n;
    logic [5:0]  r_j, n_j;
    logic [5:0]  r_taps;
    logic [6:0]  r_up;
    logic [35:0] r_step;
    logic [2:0]  r_chan;

    logic [5:0]  taps_eff;
    logic [6:0]  upf_eff;
    logic [35:0] st_eff;
    logic        rational;
    logic        emit_ok;
    logic [39:0] fin_pos;
    logic [5:0]  phase_nxt;
    logic [7:0]  int_dec;
    t_dp_cmd     cmd;

    always_comb begin
        if (r_taps == 6'd0) begin
            taps_eff = 6'd1;
        end else if (32'(r_taps) > MAX_TAPS) begin
            taps_eff = 6'(MAX_TAPS);
        end else begin
            taps_eff = r_taps;
        end
        if (r_up == 7'd0) begin
            upf_eff = 7'd1;
        end else if (r_up > 7'd64) begin
            upf_eff = 7'd64;
        end else begin
            upf_eff = r_up;
        end
        st_eff    = (r_step < MIN_STEP) ? MIN_STEP : r_step;
        rational  = (r_step == 36'd0);
        emit_ok   = (r_pos[39:32] == 8'd0) && (r_n < 7'(MAX_RESULTS));
        int_dec   = (r_pos[39:32] != 8'd0) ? r_pos[39:32] - 8'd1 : r_pos[39:32];
        fin_pos   = {int_dec, rational ? 32'd0 : r_pos[31:0]};
        phase_nxt = (({1'b0, r_phase} + 7'd1) >= upf_eff) ? 6'd0 : r_phase + 6'd1;
    end

    assign o_taps  = taps_eff;
    assign o_lanes = (r_chan == 3'd0) ? 3'd1 : r_chan;
    assign o_phase = r_phase;
    assign o_row   = rational ? ROW_W'(r_phase) : ROW_W'(r_pos[31:FRAC_BITS]);
    assign o_frac  = rational ? '0 : r_pos[FRAC_BITS-1:0];
    assign o_cmd   = cmd;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_n     = r_n;
        n_j     = r_j;
        cmd     = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_action)
                        ACT_SAMPLE: begin
                            cmd.push = 1'b1;
                            n_n      = 7'd0;
                            n_state  = S_CHECK;
                        end
                        ACT_COEF: cmd.coef_we = 1'b1;
                        ACT_ADV:  cmd.adv_we  = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (emit_ok) begin
                    n_state = S_SETUP;
                end else begin
                    n_pos   = fin_pos;
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_j       = 6'd0;
                n_state   = S_ISSUE;
            end
            S_ISSUE: begin
                cmd.issue    = 1'b1;
                cmd.first    = (r_j == 6'd0);
                cmd.last_tap = (r_j == taps_eff - 6'd1);
                if (r_j == 6'd0) begin
                    n_n = r_n + 7'd1;
                    if (rational) begin
                        n_pos[39:32] = r_pos[39:32] + i_sts.adv_data;
                        n_phase      = phase_nxt;
                    end else begin
                        n_pos = r_pos + {4'd0, st_eff};
                    end
                end
                if (r_j == taps_eff - 6'd1) begin
                    n_state = S_WAIT;
                end else begin
                    n_j = r_j + 6'd1;
                end
            end
            S_WAIT: begin
                if (i_sts.acc_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    cmd.load_out    = 1'b1;
                    cmd.last_of_run = !emit_ok;
                    if (!emit_ok) begin
                        n_pos   = fin_pos;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_phase <= '0;
            r_n     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_n     <= n_n;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= 6'd32;
            r_up   <= 7'd1;
            r_step <= '0;
            r_chan <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TAPS: r_taps <= i_cfg_data[5:0];
                REG_UP:   r_up   <= i_cfg_data[6:0];
                REG_STEP: r_step <= i_cfg_data;
                REG_CHAN: r_chan <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.acc_done |-> r_state == S_WAIT) else $error("accumulator done outside wait");
    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 7'(MAX_RESULTS)) else $error("run count beyond cap");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && cmd.last_of_run) |=> r_state == S_IDLE)
        else $error("final result did not end the run");
    a_sample_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> (r_state == S_CHECK && r_n == 7'd0)) else $error("sample did not start run");
`endif

endmodule

[rtl/prs_dp.sv]
module prs_dp #(
    parameter int MAX_TAPS  = 32,
    parameter int FRAC_BITS = 26
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  prs_pkg::t_dp_cmd        i_cmd,
    output prs_pkg::t_dp_sts        o_sts,
    input  logic [((33 - FRAC_BITS > 7) ? 33 - FRAC_BITS : 7)-1:0] i_row,
    input  logic [FRAC_BITS-1:0]    i_frac,
    input  logic [5:0]              i_taps,
    input  logic [2:0]              i_lanes,
    input  logic [5:0]              i_phase,
    input  prs_pkg::t_in_item       i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output prs_pkg::t_out_item      o_item
);
    import prs_pkg::*;

    localparam int ROW_W      = (33 - FRAC_BITS > 7) ? 33 - FRAC_BITS : 7;
    localparam int COEF_ROWS  = (1 << (32 - FRAC_BITS)) + 1;
    localparam int COEF_DEPTH = COEF_ROWS * MAX_TAPS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int HA_W       = $clog2(MAX_TAPS);
    localparam int IDX_W      = ROW_W + 7;
    localparam int PROD_W     = COEF_W + FRAC_BITS + 2;
    localparam int ROW_BITS   = LANES * SAMPLE_W;

    logic signed [COEF_W-1:0] mem_coef [COEF_DEPTH];
    logic [7:0]               mem_adv [ADV_DEPTH];
    logic [ROW_BITS-1:0]      mem_hist [MAX_TAPS];
    logic [MAX_TAPS-1:0]      r_hval;
    logic [HA_W-1:0]          r_head, n_head;
    logic [7:0]               r_adv;

    logic [IDX_W-1:0]         r_cidx0, r_cidx1;
    logic [HA_W-1:0]          r_hptr;
    logic [FRAC_BITS-1:0]     r_frac;
    logic [IDX_W-1:0]         base;
    logic [HA_W:0]            hstart;

    logic                     r1_v, r1_first, r1_last, r1_oob0, r1_oob1, r1_hv;
    logic signed [COEF_W-1:0] r1_c0, r1_c1;
    logic [ROW_BITS-1:0]      r1_h;
    logic                     r2_v, r2_first, r2_last;
    logic signed [PROD_W-1:0] r2_prod;
    logic signed [COEF_W-1:0] r2_c0;
    logic [ROW_BITS-1:0]      r2_h;
    logic                     r3_v, r3_first, r3_last;
    logic signed [COEF_W-1:0] r3_coef;
    logic [ROW_BITS-1:0]      r3_h;
    logic                     r4_v, r4_first, r4_last;
    logic signed [PROD_LANE_W-1:0] r4_p [LANES];
    logic signed [ACC_W-1:0]  r_acc [LANES];
    logic                     r_done;

    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [COEF_W-1:0] c0m, c1m;
    logic signed [COEF_W:0]   dlt;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SAMPLE_W-1:0] res [LANES];
    logic signed [ACC_W-1:0]  sh;

    assign n_head = (r_head == HA_W'(MAX_TAPS - 1)) ? '0 : r_head + HA_W'(1);
    assign base   = IDX_W'(i_row) * IDX_W'(i_taps);
    always_comb begin
        hstart = {1'b0, r_head} + (HA_W + 1)'(MAX_TAPS) - (HA_W + 1)'(i_taps)
                 + (HA_W + 1)'(1);
        if (hstart >= (HA_W + 1)'(MAX_TAPS)) begin
            hstart = hstart - (HA_W + 1)'(MAX_TAPS);
        end
    end

    // table writes and history push
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_we && (32'(i_item.table_address) < COEF_DEPTH)) begin
            mem_coef[CA_W'(i_item.table_address)] <= i_item.table_value;
        end
        if (i_cmd.adv_we && (32'(i_item.table_address) < ADV_DEPTH)) begin
            mem_adv[i_item.table_address[5:0]] <= i_item.table_value[7:0];
        end
        if (i_cmd.push) begin
            mem_hist[n_head] <= {i_item.sample_d, i_item.sample_c,
                                 i_item.sample_b, i_item.sample_a};
        end
        if (i_cmd.setup) begin
            r_adv <= mem_adv[i_phase];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_hval <= '0;
        end else if (i_cmd.push) begin
            r_head         <= n_head;
            r_hval[n_head] <= 1'b1;
        end
    end

    // tap address counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cidx0 <= base;
            r_cidx1 <= base + IDX_W'(i_taps);
            r_hptr  <= hstart[HA_W-1:0];
            r_frac  <= i_frac;
        end else if (i_cmd.issue) begin
            r_cidx0 <= r_cidx0 + IDX_W'(1);
            r_cidx1 <= r_cidx1 + IDX_W'(1);
            r_hptr  <= (r_hptr == HA_W'(MAX_TAPS - 1)) ? '0 : r_hptr + HA_W'(1);
        end
    end

    // stage 1: memory reads
    always_ff @(posedge i_clk) begin
        r1_c0    <= mem_coef[CA_W'(r_cidx0)];
        r1_c1    <= mem_coef[CA_W'(r_cidx1)];
        r1_oob0  <= (32'(r_cidx0) >= COEF_DEPTH);
        r1_oob1  <= (32'(r_cidx1) >= COEF_DEPTH);
        r1_h     <= mem_hist[r_hptr];
        r1_hv    <= r_hval[r_hptr];
        r1_first <= i_cmd.first;
        r1_last  <= i_cmd.last_tap;
    end

    // stage 2: coefficient slope times fraction
    // a zero fraction needs no next row, so that row is not used
    assign c0m = r1_oob0 ? '0 : r1_c0;
    assign c1m = r1_oob1 ? '0 : ((r_frac == '0) ? c0m : r1_c1);
    assign dlt = (COEF_W + 1)'(c1m) - (COEF_W + 1)'(c0m);
    always_ff @(posedge i_clk) begin
        r2_prod  <= PROD_W'(dlt) * $signed({2'b00, r_frac});
        r2_c0    <= c0m;
        r2_h     <= r1_hv ? r1_h : '0;
        r2_first <= r1_first;
        r2_last  <= r1_last;
    end

    // stage 3: rounded interpolation
    assign rnd = (r2_prod + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    always_ff @(posedge i_clk) begin
        r3_coef  <= r2_c0 + rnd[COEF_W-1:0];
        r3_h     <= r2_h;
        r3_first <= r2_first;
        r3_last  <= r2_last;
    end

    // stage 4: lane products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r4_p[k] <= PROD_LANE_W'($signed(r3_h[k*SAMPLE_W +: SAMPLE_W]))
                       * PROD_LANE_W'(r3_coef);
        end
        r4_first <= r3_first;
        r4_last  <= r3_last;
    end

    // stage 5: accumulate
    always_ff @(posedge i_clk) begin
        if (r4_v) begin
            for (int k = 0; k < LANES; k++) begin
                r_acc[k] <= (r4_first ? '0 : r_acc[k]) + ACC_W'(r4_p[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_v   <= i_cmd.issue;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r_done <= r4_v && r4_last;
        end
    end

    // round, saturate and mask unused lanes
    always_comb begin
        sh = '0;
        for (int k = 0; k < LANES; k++) begin
            sh = (r_acc[k] + ACC_W'(1 << 17)) >>> 18;
            if (3'(k) >= i_lanes) begin
                res[k] = '0;
            end else if (sh > ACC_W'(8388607)) begin
                res[k] = 24'sh7FFFFF;
            end else if (sh < -ACC_W'(8388608)) begin
                res[k] = 24'sh800000;
            end else begin
                res[k] = sh[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.result_a    <= res[0];
            r_out.result_b    <= res[1];
            r_out.result_c    <= res[2];
            r_out.result_d    <= res[3];
            r_out.last_of_run <= i_cmd.last_of_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_item         = r_out;
    assign o_sts.acc_done = r_done;
    assign o_sts.out_busy = r_out_valid;
    assign o_sts.adv_data = r_adv;

endmodule

[rtl/polyphase_resampler.sv]
// channel   direction  transfer
// i_in      sink       one sample frame or one table load per transfer
// o_out     source     one output frame per transfer, last_of_run on the final one
// i_cfg_*   write      one register per enabled cycle
//
// a load item is written while idle and does not hold off the next item; a sample frame
// sends each output frame through the single shared tap multiply-accumulate pipeline
// reset clears the control state and the history valid bits at once, no clearing pass
// a waiting output holds the next output frame in the accumulator until taken
// a new item is taken once the last output frame of the run is in the output register
module polyphase_resampler #(
    parameter int MAX_TAPS  = 32,
    parameter int FRAC_BITS = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    prs_in_if.sink                         i_in,
    prs_out_if.source                      o_out
);
    import prs_pkg::*;

    localparam int ROW_W = (33 - FRAC_BITS > 7) ? 33 - FRAC_BITS : 7;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [ROW_W-1:0]     row;
    logic [FRAC_BITS-1:0] frac;
    logic [5:0]           taps;
    logic [2:0]           lanes;
    logic [5:0]           phase;

    prs_ctrl #(
        .MAX_TAPS  (MAX_TAPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_action    (i_in.data.action),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_row       (row),
        .o_frac      (frac),
        .o_taps      (taps),
        .o_lanes     (lanes),
        .o_phase     (phase)
    );

    prs_dp #(
        .MAX_TAPS  (MAX_TAPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_row   (row),
        .i_frac  (frac),
        .i_taps  (taps),
        .i_lanes (lanes),
        .i_phase (phase),
        .i_item  (i_in.data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule
